// ===== rtl/core/mtw_pkg.sv =====
// mtw_pkg: shared widths, register indexes and the event word type for the
// missing-tooth wheel trigger core. No dependencies.
package mtw_pkg;

	localparam int INTERVAL_BITS = 16;
	localparam int EXT_W         = (INTERVAL_BITS > 16) ? INTERVAL_BITS : 16;
	localparam int TOOTH_W       = 8;
	localparam int PERIOD_W      = 16;
	localparam int WIDTH_W       = 8;
	localparam int PULSE_W       = 15;
	localparam int CFG_IDX_W     = 8;
	localparam int CFG_DATA_W    = 8;

	localparam logic [TOOTH_W-1:0]    TOOTH_MAX  = '1;
	localparam logic [PERIOD_W-1:0]   PERIOD_MAX = '1;
	localparam logic [PULSE_W-1:0]    TICKS_PER_UNIT = 15'd100;

	localparam logic [CFG_IDX_W-1:0]  REG_PULSE_WIDTH = 8'd0;
	localparam logic [CFG_IDX_W-1:0]  REG_FIRE_TOOTH  = 8'd1;

	localparam logic [WIDTH_W-1:0]    PULSE_WIDTH_RST = 8'd50;
	localparam logic [TOOTH_W-1:0]    FIRE_TOOTH_RST  = 8'd5;

	typedef struct packed {
		logic                edge_seen;
		logic                gap;
		logic                fire;
		logic [TOOTH_W-1:0]  tooth_number;
		logic [PERIOD_W-1:0] period;
	} tooth_evt_t;

endpackage

// ===== rtl/core/missing_tooth_wheel_pulse_trigger_core.sv =====
// Missing-tooth wheel decoder and one-shot trigger. One input word is one 1 us
// tick and gives exactly one result word; a tick is taken every clock cycle
// unless in_stall holds it off for a stalled full result register or an offered
// configuration write. Each tick passes the input register, then the update of
// interval, tooth count and pulse timer, then the result register. A configuration
// write waits until the input register is empty and holds off input words while
// it is offered. Configuration uses mtw_pkg.
module missing_tooth_wheel_pulse_trigger_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              tooth_edge,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              pulse_out,
	output logic                              tooth_event,
	output logic                              gap_found,
	output logic [mtw_pkg::TOOTH_W-1:0]       tooth_number,
	output logic [mtw_pkg::PERIOD_W-1:0]      tooth_period_us,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mtw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mtw_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic                          valid_s1;
	logic                          edge_s1;
	logic                          out_valid_q;
	logic                          pulse_q;
	logic                          event_q;
	logic                          gap_q;
	logic [mtw_pkg::TOOTH_W-1:0]   tooth_q;
	logic [mtw_pkg::PERIOD_W-1:0]  period_q;
	logic [mtw_pkg::WIDTH_W-1:0]   width_q;
	logic [mtw_pkg::TOOTH_W-1:0]   fire_tooth_q;
	logic                          advance;
	logic                          in_take;
	logic                          pulse;
	mtw_pkg::tooth_evt_t           evt;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = (valid_s1 && !advance) || cfg_valid;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = !valid_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= mtw_pkg::PULSE_WIDTH_RST;
			fire_tooth_q <= mtw_pkg::FIRE_TOOTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mtw_pkg::REG_PULSE_WIDTH: width_q      <= cfg_data;
				mtw_pkg::REG_FIRE_TOOTH:  fire_tooth_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			edge_s1 <= tooth_edge;
		end
	end

	mtw_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.edge_in    (edge_s1),
		.fire_tooth (fire_tooth_q),
		.evt        (evt)
	);

	mtw_pulse u_pulse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.fire   (evt.fire),
		.width  (width_q),
		.pulse  (pulse)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pulse_q  <= pulse;
			event_q  <= evt.edge_seen;
			gap_q    <= evt.gap;
			tooth_q  <= evt.tooth_number;
			period_q <= evt.period;
		end
	end

	assign out_valid       = out_valid_q;
	assign pulse_out       = pulse_q;
	assign tooth_event     = event_q;
	assign gap_found       = gap_q;
	assign tooth_number    = tooth_q;
	assign tooth_period_us = period_q;

	a_gap_restarts_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && gap_found |-> tooth_event && tooth_number == 8'd1)
		else $error("gap word without edge or count not restarted");

	a_edge_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tooth_event |-> tooth_number != '0)
		else $error("edge word with zero tooth count");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> cfg_valid || (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with room downstream");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("advanced word missing from result register");

endmodule

// ===== rtl/core/mtw_decode.sv =====
// mtw_decode: interval counter, gap test, tooth count and period latch.
// Depends on mtw_pkg.
module mtw_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          edge_in,
	input  logic [mtw_pkg::TOOTH_W-1:0]   fire_tooth,
	output mtw_pkg::tooth_evt_t           evt
);

	localparam int IB = mtw_pkg::INTERVAL_BITS;

	logic [IB-1:0]                     interval_q;
	logic [IB-1:0]                     prev_interval_q;
	logic [mtw_pkg::TOOTH_W-1:0]       tooth_count_q;
	logic [mtw_pkg::PERIOD_W-1:0]      period_q;

	logic [IB-1:0]                     measured;
	logic [IB:0]                       prev_x2;
	logic [mtw_pkg::EXT_W-1:0]         measured_ext;
	logic [mtw_pkg::PERIOD_W-1:0]      period_sat;
	logic [mtw_pkg::TOOTH_W-1:0]       count_inc;
	logic                              gap;
	logic [mtw_pkg::TOOTH_W-1:0]       count_nxt;
	logic [mtw_pkg::PERIOD_W-1:0]      period_nxt;

	always_comb begin
		measured     = (interval_q == {IB{1'b1}}) ? interval_q : interval_q + 1'b1;
		prev_x2      = {prev_interval_q, 1'b0};
		gap          = ({1'b0, measured} > prev_x2);
		measured_ext = mtw_pkg::EXT_W'(measured);
		period_sat   = (measured_ext > mtw_pkg::EXT_W'(mtw_pkg::PERIOD_MAX)) ?
		               mtw_pkg::PERIOD_MAX : measured_ext[mtw_pkg::PERIOD_W-1:0];
		count_inc    = (tooth_count_q == mtw_pkg::TOOTH_MAX) ? tooth_count_q
		               : tooth_count_q + 1'b1;
		count_nxt    = tooth_count_q;
		period_nxt   = period_q;
		if (edge_in) begin
			if (gap) begin
				count_nxt = mtw_pkg::TOOTH_W'(1);
			end else begin
				count_nxt  = count_inc;
				period_nxt = period_sat;
			end
		end
		evt.edge_seen    = edge_in;
		evt.gap          = edge_in && gap;
		evt.fire         = edge_in && !gap && (count_inc == fire_tooth);
		evt.tooth_number = count_nxt;
		evt.period       = period_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q      <= '0;
			prev_interval_q <= '0;
			tooth_count_q   <= '0;
			period_q        <= '0;
		end else if (step) begin
			tooth_count_q <= count_nxt;
			period_q      <= period_nxt;
			if (edge_in) begin
				interval_q      <= '0;
				prev_interval_q <= measured;
			end else begin
				interval_q <= measured;
			end
		end
	end

endmodule

// ===== rtl/core/mtw_pulse.sv =====
// mtw_pulse: one-shot pulse timer, restarted on each firing edge.
// Depends on mtw_pkg.
module mtw_pulse (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          fire,
	input  logic [mtw_pkg::WIDTH_W-1:0]   width,
	output logic                          pulse
);

	logic [mtw_pkg::PULSE_W-1:0] remaining_q;
	logic [mtw_pkg::PULSE_W-1:0] load;
	logic [mtw_pkg::PULSE_W-1:0] cur;

	always_comb begin
		load  = mtw_pkg::PULSE_W'(width) * mtw_pkg::TICKS_PER_UNIT;
		cur   = fire ? load : remaining_q;
		pulse = (cur != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
		end else if (step) begin
			remaining_q <= pulse ? cur - 1'b1 : cur;
		end
	end

endmodule

// ===== bench/missing_tooth_wheel_pulse_trigger_core_tb.sv =====
`timescale 1ns / 100ps
// bench for missing_tooth_wheel_pulse_trigger_core: feeds wheel tick words, predicts each
// result word and checks them in order under random idling on both sides.
// Depends on mtw_pkg and the core RTL.
module missing_tooth_wheel_pulse_trigger_core_tb;

	localparam int RANDOM_TICKS   = 420;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic                         pulse;
		logic                         evt;
		logic                         gap;
		logic [mtw_pkg::TOOTH_W-1:0]  number;
		logic [mtw_pkg::PERIOD_W-1:0] period;
	} wheel_word_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic                           tooth_edge = 1'b0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic                           pulse_out;
	logic                           tooth_event;
	logic                           gap_found;
	logic [mtw_pkg::TOOTH_W-1:0]    tooth_number;
	logic [mtw_pkg::PERIOD_W-1:0]   tooth_period_us;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [mtw_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [mtw_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state and register copies
	logic [mtw_pkg::INTERVAL_BITS-1:0] span_ticks = '0;
	logic [mtw_pkg::INTERVAL_BITS-1:0] last_span = '0;
	logic [mtw_pkg::TOOTH_W-1:0]       tooth_cnt = '0;
	logic [mtw_pkg::PERIOD_W-1:0]      held_period = '0;
	logic [mtw_pkg::PULSE_W-1:0]       pulse_left = '0;
	logic [mtw_pkg::WIDTH_W-1:0]       width_units = mtw_pkg::PULSE_WIDTH_RST;
	logic [mtw_pkg::TOOTH_W-1:0]       fire_at = mtw_pkg::FIRE_TOOTH_RST;

	wheel_word_t wheel_expect_q[$];
	wheel_word_t seen_word;
	wheel_word_t want_word;
	int          mismatch_count = 0;
	int          ticks_sent = 0;
	logic        calm = 1'b0;

	missing_tooth_wheel_pulse_trigger_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.tooth_edge      (tooth_edge),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pulse_out       (pulse_out),
		.tooth_event     (tooth_event),
		.gap_found       (gap_found),
		.tooth_number    (tooth_number),
		.tooth_period_us (tooth_period_us),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		out_stall = !calm && ($urandom_range(99) < 17);
	end

	function automatic wheel_word_t wheel_advance(input logic edge_bit);
		wheel_word_t word;
		logic        gap_hit;
		logic        fire_now;
		gap_hit = 1'b0;
		fire_now = 1'b0;
		if (span_ticks != '1) begin
			span_ticks = span_ticks + 1'b1;
		end
		if (edge_bit) begin
			if ({1'b0, span_ticks} > {last_span, 1'b0}) begin
				gap_hit = 1'b1;
				tooth_cnt = mtw_pkg::TOOTH_W'(1);
			end else begin
				if (tooth_cnt != mtw_pkg::TOOTH_MAX) begin
					tooth_cnt = tooth_cnt + 1'b1;
				end
				held_period = (mtw_pkg::EXT_W'(span_ticks) >
					mtw_pkg::EXT_W'(mtw_pkg::PERIOD_MAX)) ?
					mtw_pkg::PERIOD_MAX : mtw_pkg::PERIOD_W'(span_ticks);
				fire_now = (tooth_cnt == fire_at);
			end
			last_span = span_ticks;
			span_ticks = '0;
		end
		if (fire_now) begin
			pulse_left = mtw_pkg::PULSE_W'(width_units) * mtw_pkg::TICKS_PER_UNIT;
		end
		word.pulse = (pulse_left != '0);
		word.evt = edge_bit;
		word.gap = gap_hit;
		word.number = tooth_cnt;
		word.period = held_period;
		if (pulse_left != '0) begin
			pulse_left = pulse_left - 1'b1;
		end
		return word;
	endfunction

	task automatic report_word(input string what, input wheel_word_t want,
			input wheel_word_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%s at %0t: expected pulse=%0b evt=%0b gap=%0b tooth=%0d period=%0d",
				what, $realtime, want.pulse, want.evt, want.gap, want.number, want.period);
			$display("    got pulse=%0b evt=%0b gap=%0b tooth=%0d period=%0d",
				got.pulse, got.evt, got.gap, got.number, got.period);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_word = {pulse_out, tooth_event, gap_found, tooth_number, tooth_period_us};
			if (wheel_expect_q.size() == 0) begin
				report_word("result word with none pending", '0, seen_word);
			end else begin
				want_word = wheel_expect_q.pop_front();
				if (seen_word.pulse !== want_word.pulse || seen_word.evt !== want_word.evt ||
						seen_word.gap !== want_word.gap ||
						seen_word.number !== want_word.number ||
						seen_word.period !== want_word.period) begin
					report_word("result word mismatch", want_word, seen_word);
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready) || !arst_n) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_tick(input logic edge_bit);
		while (!calm && $urandom_range(99) < 17) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		tooth_edge = edge_bit;
		wheel_expect_q.push_back(wheel_advance(edge_bit));
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic send_quiet(input int n);
		repeat (n) send_tick(1'b0);
	endtask

	// n ticks ending in an edge, so the edge measures an interval of n
	task automatic send_interval(input int n);
		send_quiet(n - 1);
		send_tick(1'b1);
	endtask

	// one revolution: the long gap interval first, then the remaining teeth
	task automatic spin_wheel(input int teeth, input int period, input int jit);
		send_interval(2 * (period + jit) + 1 + $urandom_range(0, period));
		repeat (teeth - 1) send_interval(period + $urandom_range(0, jit));
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (wheel_expect_q.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [mtw_pkg::CFG_IDX_W-1:0] idx,
			input logic [mtw_pkg::CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		if (idx == mtw_pkg::REG_PULSE_WIDTH) begin
			width_units = data;
		end else if (idx == mtw_pkg::REG_FIRE_TOOTH) begin
			fire_at = data;
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// first edge is a gap, adjacent edges, an interval of exactly twice, default firing
	task automatic test_reset_values();
		send_quiet(2);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		send_interval(2);
		send_interval(2);
		send_interval(5);
		send_quiet(3);
	endtask

	task automatic test_unreachable_teeth();
		settle();
		write_reg(mtw_pkg::REG_FIRE_TOOTH, 8'd0);
		spin_wheel(6, 2, 0);
		spin_wheel(6, 2, 0);
		settle();
		write_reg(mtw_pkg::REG_FIRE_TOOTH, 8'd1);
		spin_wheel(6, 3, 1);
		spin_wheel(6, 3, 1);
	endtask

	task automatic test_bad_index();
		settle();
		write_reg(mtw_pkg::REG_PULSE_WIDTH, 8'd2);
		write_reg(mtw_pkg::REG_FIRE_TOOTH, 8'd3);
		write_reg(8'hFF, 8'h00);
		write_reg(8'h02, 8'hFF);
		repeat (6) write_reg(mtw_pkg::CFG_IDX_W'($urandom_range(2, 255)),
			mtw_pkg::CFG_DATA_W'($urandom_range(0, 255)));
		spin_wheel(5, 2, 0);
		spin_wheel(5, 2, 0);
	endtask

	task automatic test_width_change();
		settle();
		write_reg(mtw_pkg::REG_PULSE_WIDTH, 8'd1);
		write_reg(mtw_pkg::REG_FIRE_TOOTH, 8'd3);
		spin_wheel(5, 3, 0);
		settle();
		// running pulse keeps its length
		write_reg(mtw_pkg::REG_PULSE_WIDTH, 8'd4);
		send_quiet(120);
		spin_wheel(5, 3, 0);
		send_quiet(450);
	endtask

	task automatic test_zero_width();
		settle();
		write_reg(mtw_pkg::REG_PULSE_WIDTH, 8'd255);
		write_reg(mtw_pkg::REG_FIRE_TOOTH, 8'd2);
		spin_wheel(4, 2, 0);
		spin_wheel(4, 2, 0);
		settle();
		write_reg(mtw_pkg::REG_PULSE_WIDTH, 8'd0);
		spin_wheel(4, 2, 0);
		spin_wheel(4, 2, 0);
	endtask

	task automatic test_tooth_saturation();
		settle();
		write_reg(mtw_pkg::REG_PULSE_WIDTH, 8'd1);
		write_reg(mtw_pkg::REG_FIRE_TOOTH, 8'd255);
		repeat (300) send_tick(1'b1);
		send_quiet(150);
		send_tick(1'b1);
	endtask

	// long intervals back to back with no idling on either side
	task automatic test_long_intervals();
		calm = 1'b1;
		send_tick(1'b1);
		send_interval(90);
		send_interval(170);
		send_interval(3);
		calm = 1'b0;
	endtask

	task automatic test_random_wheels();
		int start;
		int next_cfg;
		int pick;
		int period;
		start = ticks_sent;
		next_cfg = ticks_sent;
		while (ticks_sent - start < RANDOM_TICKS) begin
			if (ticks_sent >= next_cfg) begin
				settle();
				pick = $urandom_range(9);
				write_reg(mtw_pkg::REG_PULSE_WIDTH, mtw_pkg::CFG_DATA_W'(
					(pick < 6) ? $urandom_range(1, 3) : (pick == 6) ? 0 :
					(pick == 7) ? 255 : $urandom_range(0, 255)));
				pick = $urandom_range(9);
				write_reg(mtw_pkg::REG_FIRE_TOOTH, mtw_pkg::CFG_DATA_W'(
					(pick < 7) ? $urandom_range(2, 12) :
					(pick == 7) ? $urandom_range(0, 1) : (pick == 8) ? 255 :
					$urandom_range(0, 255)));
				calm = ($urandom_range(4) == 0);
				next_cfg = ticks_sent + $urandom_range(150, 400);
			end
			pick = $urandom_range(9);
			period = $urandom_range(1, 8);
			if (pick < 7) begin
				spin_wheel($urandom_range(2, 16), period, period / 3);
			end else if (pick == 7) begin
				spin_wheel($urandom_range(2, 16), period, period);
			end else begin
				repeat ($urandom_range(5, 30)) send_tick($urandom_range(99) < 30);
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_values();
		test_unreachable_teeth();
		test_bad_index();
		test_width_change();
		test_zero_width();
		test_tooth_saturation();
		test_long_intervals();
		test_random_wheels();
		settle();
		repeat (8) @(posedge clk);
		if (wheel_expect_q.size() != 0) begin
			report_word("result word never arrived", wheel_expect_q[0], '0);
		end
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
